// ----- src/trm_pkg.sv -----
// Shared types and constants for the tetraploid relationship matrix core.
// Used by every module of the block; depends on nothing else.

`default_nettype none

package trm_pkg;

  // Default store size in individuals; the top level hands it down.
  localparam int unsigned MAX_INDIVIDUALS_DEF = 64;

  // Fixed field widths of the ports.
  localparam int unsigned IDX_IN_W = 7;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned VAL_W    = 21;
  localparam int unsigned RATE_W   = 17;

  // Stored value width, unsigned Q4.16 of four times the relationship.
  localparam int unsigned REL_W = 20;

  // Product of a parent sum (REL_W+1 bits) and 1-w (RATE_W bits).
  localparam int unsigned PROD_W = REL_W + 1 + RATE_W;

  // Diagonal numerator in Q.16 before the divide by six.
  localparam int unsigned DIV_W = 24;

  // Divide by six as a multiply by ceil(2^26/6) and a shift by 26. The
  // result is the exact floor for every numerator below 2^25.
  localparam logic [DIV_W-1:0] RECIP_SIX   = 24'd11184811;
  localparam int unsigned      RECIP_SHIFT = 26;

  localparam logic [RATE_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [REL_W-1:0]  REL_MAX = 20'hFFFFF;

  // Constant parts of the diagonal numerator, already in Q.16.
  localparam logic [DIV_W-1:0] BASE_TWO_PARENTS = 24'd262144;  // 4.0
  localparam logic [DIV_W-1:0] BASE_ONE_PARENT  = 24'd327680;  // 5.0
  localparam logic [DIV_W-1:0] ROUND_HALF_SIX   = 24'd3;       // half of 6 for rounding

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_COLS,
    ST_DWAIT
  } trm_state_e;

  typedef struct packed {
    logic load_prod;
    logic has_s;
    logic has_d;
  } trm_arith_ctl_t;

endpackage

`default_nettype wire

// ----- src/trm_store.sv -----
// Relationship store: lower triangle of the matrix, one write and two reads a cycle.
// Read data is registered. Depends on trm_pkg.

`default_nettype none

module trm_store #(
  parameter int unsigned IDX_W = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [2*IDX_W-1:0]         waddr_i,
  input  wire logic [trm_pkg::REL_W-1:0]  wdata_i,
  input  wire logic [2*IDX_W-1:0]         raddr_a_i,
  input  wire logic [2*IDX_W-1:0]         raddr_b_i,
  output logic      [trm_pkg::REL_W-1:0]  rdata_a_o,
  output logic      [trm_pkg::REL_W-1:0]  rdata_b_o
);

  localparam int unsigned DEPTH = 1 << (2 * IDX_W);

  logic [trm_pkg::REL_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- src/trm_arith.sv -----
// Shared arithmetic: column halving, the diagonal product and a reciprocal divide by six.
// Depends on trm_pkg.

`default_nettype none

module trm_arith (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire trm_pkg::trm_arith_ctl_t     ctl_i,
  input  wire logic [trm_pkg::RATE_W-1:0]  rate_i,
  input  wire logic [trm_pkg::REL_W-1:0]   rdata_a_i,
  input  wire logic [trm_pkg::REL_W-1:0]   rdata_b_i,
  output logic      [trm_pkg::REL_W-1:0]   col_value_o,
  output logic      [trm_pkg::REL_W-1:0]   diag_value_o,
  output logic                             diag_ready_o
);

  localparam int unsigned RecipW = 2 * trm_pkg::DIV_W;

  logic [trm_pkg::REL_W-1:0]    a_sel, b_sel;
  logic [trm_pkg::REL_W:0]      pair_sum, round_sum;
  logic [trm_pkg::RATE_W-1:0]   w_sat, omw;
  logic [trm_pkg::RATE_W:0]     founder_sum;
  logic [trm_pkg::PROD_W-1:0]   prod_q;
  logic                         stage_q;
  logic                         both, founder;
  logic [trm_pkg::DIV_W-1:0]    base_term, w8, w_term, sd_term, prod_term, dividend;
  logic [trm_pkg::DIV_W-1:0]    quo_q;
  logic [RecipW-1:0]            recip_prod;
  logic                         div_busy_q, founder_q;
  logic [trm_pkg::REL_W-1:0]    quo_sat;

  // An unknown parent contributes zero, so one adder serves every case.
  assign a_sel     = ctl_i.has_s ? rdata_a_i : '0;
  assign b_sel     = ctl_i.has_d ? rdata_b_i : '0;
  assign pair_sum  = {1'b0, a_sel} + {1'b0, b_sel};
  assign round_sum = pair_sum + {{trm_pkg::REL_W{1'b0}}, 1'b1};
  assign col_value_o = round_sum[trm_pkg::REL_W:1];

  assign w_sat       = (rate_i > trm_pkg::ONE_Q16) ? trm_pkg::ONE_Q16 : rate_i;
  assign omw         = trm_pkg::ONE_Q16 - w_sat;
  assign founder_sum = {1'b0, trm_pkg::ONE_Q16} + {1'b0, w_sat};

  assign both    = ctl_i.has_s & ctl_i.has_d;
  assign founder = ~ctl_i.has_s & ~ctl_i.has_d;

  // Numerator in Q.16 with the rounding term folded in; the low product bits
  // only matter through the floor, so dropping them is exact.
  assign base_term = both ? trm_pkg::BASE_TWO_PARENTS : trm_pkg::BASE_ONE_PARENT;
  assign w8        = trm_pkg::DIV_W'({w_sat, 3'b000});
  assign w_term    = ctl_i.has_s ? w8 : (w8 - trm_pkg::DIV_W'(w_sat));
  assign sd_term   = both ? (trm_pkg::DIV_W'({rdata_a_i, 1'b0}) + trm_pkg::DIV_W'(rdata_a_i))
                          : '0;
  assign prod_term = trm_pkg::DIV_W'(prod_q[trm_pkg::PROD_W-1:16]);
  assign dividend  = base_term + w_term + sd_term + trm_pkg::ROUND_HALF_SIX + prod_term;

  // The numerator stays below 2^23, well inside the exact range of the reciprocal.
  assign recip_prod = RecipW'(quo_q) * RecipW'(trm_pkg::RECIP_SIX);

  assign quo_sat = (quo_q[trm_pkg::DIV_W-1:trm_pkg::REL_W] != '0)
                 ? trm_pkg::REL_MAX : quo_q[trm_pkg::REL_W-1:0];
  assign diag_value_o = founder_q ? trm_pkg::REL_W'(founder_sum) : quo_sat;
  assign diag_ready_o = ~div_busy_q & ~stage_q & ~ctl_i.load_prod;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_prod) begin
      prod_q <= trm_pkg::PROD_W'(pair_sum) * trm_pkg::PROD_W'(omw);
    end
  end

  // The numerator is registered first, then replaced by its quotient.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= 1'b0;
      div_busy_q <= 1'b0;
      founder_q  <= 1'b0;
      quo_q      <= '0;
    end else begin
      stage_q <= ctl_i.load_prod;
      if (stage_q) begin
        quo_q      <= dividend;
        founder_q  <= founder;
        div_busy_q <= ~founder;
      end else if (div_busy_q) begin
        quo_q      <= trm_pkg::DIV_W'(recip_prod[RecipW-1:trm_pkg::RECIP_SHIFT]);
        div_busy_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/trm_ctrl.sv -----
// Sequencer: takes an entry, reads parent values, streams the new row and the diagonal.
// Depends on trm_pkg.

`default_nettype none

module trm_ctrl #(
  parameter  int unsigned MAX_INDIVIDUALS = trm_pkg::MAX_INDIVIDUALS_DEF,
  localparam int unsigned IdxW            = $clog2(MAX_INDIVIDUALS)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [trm_pkg::IDX_IN_W-1:0]  sire_i,
  input  wire logic [trm_pkg::IDX_IN_W-1:0]  dam_i,
  input  wire logic                          new_ped_i,
  output logic                               busy_o,
  output logic      [2*IdxW-1:0]             raddr_a_o,
  output logic      [2*IdxW-1:0]             raddr_b_o,
  output logic                               we_o,
  output logic      [2*IdxW-1:0]             waddr_o,
  output logic      [trm_pkg::REL_W-1:0]     wdata_o,
  input  wire logic [trm_pkg::REL_W-1:0]     col_value_i,
  input  wire logic [trm_pkg::REL_W-1:0]     diag_value_i,
  input  wire logic                          diag_ready_i,
  output trm_pkg::trm_arith_ctl_t            arith_ctl_o,
  output logic                               res_valid_o,
  output logic      [IdxW-1:0]               res_col_o,
  output logic      [trm_pkg::REL_W-1:0]     res_value_o,
  output logic                               res_flag_o,
  output logic                               res_full_o,
  output logic                               res_last_o
);

  localparam int unsigned CntW = $clog2(MAX_INDIVIDUALS + 1);
  localparam int unsigned CmpW = trm_pkg::IDX_IN_W + 1;

  trm_pkg::trm_state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d, count_eff;
  logic [IdxW-1:0] row_q, row_d, col_q, col_d, sire_q, sire_d, dam_q, dam_d;
  logic [IdxW-1:0] pipe_col_q, pipe_col_d;
  logic            pipe_vld_q, pipe_vld_d;
  logic            has_s_q, has_s_d, has_d_q, has_d_d, flag_q, flag_d;
  logic            res_vld_q, res_vld_d, res_flag_q, res_flag_d;
  logic            res_full_q, res_full_d, res_last_q, res_last_d;
  logic [IdxW-1:0] res_col_q, res_col_d;
  logic [trm_pkg::REL_W-1:0] res_val_q, res_val_d;

  logic            accept, full, last_col, diag_emit;
  logic            s_known, d_known, s_bad, d_bad;
  logic [trm_pkg::IDX_IN_W-1:0] sire_m1, dam_m1;
  logic [IdxW-1:0] sd_hi, sd_lo, cs_hi, cs_lo, cd_hi, cd_lo;

  assign busy_o    = (state_q != trm_pkg::ST_IDLE);
  assign accept    = start_i & ~busy_o;
  assign count_eff = new_ped_i ? '0 : count_q;
  assign full      = (count_eff == CntW'(MAX_INDIVIDUALS));

  assign s_known = (sire_i != '0);
  assign d_known = (dam_i != '0);
  assign s_bad   = s_known & ({1'b0, sire_i} > CmpW'(count_eff));
  assign d_bad   = d_known & ({1'b0, dam_i} > CmpW'(count_eff));
  assign sire_m1 = sire_i - trm_pkg::IDX_IN_W'(1);
  assign dam_m1  = dam_i - trm_pkg::IDX_IN_W'(1);

  assign last_col  = (col_q == row_q - IdxW'(1));
  assign diag_emit = (state_q == trm_pkg::ST_DWAIT) & diag_ready_i & ~pipe_vld_q;

  // Only the lower triangle is kept, so every read goes to (larger, smaller).
  assign sd_hi = (sire_q > dam_q) ? sire_q : dam_q;
  assign sd_lo = (sire_q > dam_q) ? dam_q : sire_q;
  assign cs_hi = (col_q > sire_q) ? col_q : sire_q;
  assign cs_lo = (col_q > sire_q) ? sire_q : col_q;
  assign cd_hi = (col_q > dam_q) ? col_q : dam_q;
  assign cd_lo = (col_q > dam_q) ? dam_q : col_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trm_pkg::ST_IDLE: begin
        if (accept && !full) begin
          state_d = trm_pkg::ST_RD0;
        end
      end
      trm_pkg::ST_RD0: begin
        state_d = trm_pkg::ST_RD1;
      end
      trm_pkg::ST_RD1: begin
        state_d = (row_q == '0) ? trm_pkg::ST_DWAIT : trm_pkg::ST_COLS;
      end
      trm_pkg::ST_COLS: begin
        if (last_col) begin
          state_d = trm_pkg::ST_DWAIT;
        end
      end
      trm_pkg::ST_DWAIT: begin
        if (diag_emit) begin
          state_d = trm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = trm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d    = count_q;
    row_d      = row_q;
    col_d      = col_q;
    sire_d     = sire_q;
    dam_d      = dam_q;
    has_s_d    = has_s_q;
    has_d_d    = has_d_q;
    flag_d     = flag_q;
    pipe_vld_d = (state_q == trm_pkg::ST_COLS);
    pipe_col_d = col_q;
    res_vld_d  = 1'b0;
    res_col_d  = res_col_q;
    res_val_d  = res_val_q;
    res_flag_d = res_flag_q;
    res_full_d = res_full_q;
    res_last_d = res_last_q;
    we_o       = 1'b0;
    waddr_o    = {row_q, pipe_col_q};
    wdata_o    = col_value_i;

    unique case (state_q)
      trm_pkg::ST_RD0: begin
        raddr_a_o = {sire_q, sire_q};
        raddr_b_o = {dam_q, dam_q};
      end
      trm_pkg::ST_RD1: begin
        raddr_a_o = {sd_hi, sd_lo};
        raddr_b_o = {sd_hi, sd_lo};
      end
      default: begin
        raddr_a_o = {cs_hi, cs_lo};
        raddr_b_o = {cd_hi, cd_lo};
      end
    endcase

    if (accept) begin
      col_d = '0;
      if (full) begin
        count_d    = count_eff;
        res_vld_d  = 1'b1;
        res_col_d  = '0;
        res_val_d  = '0;
        res_flag_d = 1'b0;
        res_full_d = 1'b1;
        res_last_d = 1'b1;
      end else begin
        count_d = count_eff + CntW'(1);
        row_d   = count_eff[IdxW-1:0];
        has_s_d = s_known & ~s_bad;
        has_d_d = d_known & ~d_bad;
        flag_d  = s_bad | d_bad;
        sire_d  = has_s_d ? sire_m1[IdxW-1:0] : '0;
        dam_d   = has_d_d ? dam_m1[IdxW-1:0] : '0;
      end
    end

    if (state_q == trm_pkg::ST_COLS) begin
      col_d = col_q + IdxW'(1);
    end

    // Each column of the row is written in the cycle after its reads were issued, and its beat is registered.
    if (pipe_vld_q) begin
      we_o       = 1'b1;
      res_vld_d  = 1'b1;
      res_col_d  = pipe_col_q;
      res_val_d  = col_value_i;
      res_flag_d = flag_q;
      res_full_d = 1'b0;
      res_last_d = 1'b0;
    end else if (diag_emit) begin
      we_o       = 1'b1;
      waddr_o    = {row_q, row_q};
      wdata_o    = diag_value_i;
      res_vld_d  = 1'b1;
      res_col_d  = row_q;
      res_val_d  = diag_value_i;
      res_flag_d = flag_q;
      res_full_d = 1'b0;
      res_last_d = 1'b1;
    end
  end

  assign arith_ctl_o.load_prod = (state_q == trm_pkg::ST_RD1);
  assign arith_ctl_o.has_s     = has_s_q;
  assign arith_ctl_o.has_d     = has_d_q;

  assign res_valid_o = res_vld_q;
  assign res_col_o   = res_col_q;
  assign res_value_o = res_val_q;
  assign res_flag_o  = res_flag_q;
  assign res_full_o  = res_full_q;
  assign res_last_o  = res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= trm_pkg::ST_IDLE;
      count_q    <= '0;
      row_q      <= '0;
      col_q      <= '0;
      sire_q     <= '0;
      dam_q      <= '0;
      has_s_q    <= 1'b0;
      has_d_q    <= 1'b0;
      flag_q     <= 1'b0;
      pipe_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      row_q      <= row_d;
      col_q      <= col_d;
      sire_q     <= sire_d;
      dam_q      <= dam_d;
      has_s_q    <= has_s_d;
      has_d_q    <= has_d_d;
      flag_q     <= flag_d;
      pipe_vld_q <= pipe_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_col_q <= pipe_col_d;
    res_col_q  <= res_col_d;
    res_val_q  <= res_val_d;
    res_flag_q <= res_flag_d;
    res_full_q <= res_full_d;
    res_last_q <= res_last_d;
  end

endmodule

`default_nettype wire

// ----- src/tetraploid_relationship_matrix_core.sv -----
// Top level of the tetraploid relationship matrix core.
// Depends on trm_pkg, trm_ctrl, trm_arith and trm_store.
//
// Each pedigree entry (sire and dam numbers, one-based, zero for unknown)
// appends one individual to a stored relationship matrix built with the
// tabular method for autotetraploids, and the block answers with the new
// row scaled by four: columns 0 to i-1 in order, then the diagonal at
// column i with last_of_row_o set. Values are unsigned Q.16 and saturate at
// 2^20-1. An entry is taken on a clock edge with start high and busy low;
// busy then stays high until the edge that puts the diagonal out. Results
// are one-cycle beats marked by result_strobe_o and cannot be held off, so
// the receiver must take every beat as it comes. For each entry the states
// ST_RD0 and ST_RD1 read the parents' diagonal and cross terms, the row
// then streams at one beat per cycle over the two read ports of the store
// while the diagonal numerator is registered and divided by six with one
// reciprocal multiply, and the diagonal beat follows the last column
// directly. A founder, or the first entry of a pedigree, gets diagonal
// 1+w. A parent number above the current count is treated as unknown and
// sets parent_flagged_o on every beat of the row. When the store is full,
// an entry without new_pedigree_i is refused with a single beat carrying
// capacity_full_o on the next cycle, and busy never rises. The double
// reduction rate w is written over the cfg port in Q1.16, values above one
// taken as one; write it only while busy is low and no row is still
// streaming. The store has no reset and needs none: only rows of the
// current pedigree are ever used.

`default_nettype none

module tetraploid_relationship_matrix_core #(
  parameter int unsigned MAX_INDIVIDUALS = trm_pkg::MAX_INDIVIDUALS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [trm_pkg::IDX_IN_W-1:0]  sire_index_i,
  input  wire logic [trm_pkg::IDX_IN_W-1:0]  dam_index_i,
  input  wire logic                          new_pedigree_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [trm_pkg::RATE_W-1:0]    cfg_data_i,
  output logic                               result_strobe_o,
  output logic      [trm_pkg::COL_W-1:0]     column_index_o,
  output logic      [trm_pkg::VAL_W-1:0]     relationship_value_o,
  output logic                               parent_flagged_o,
  output logic                               capacity_full_o,
  output logic                               last_of_row_o
);

  localparam int unsigned IdxW = $clog2(MAX_INDIVIDUALS);

  logic [trm_pkg::RATE_W-1:0] rate_q;

  logic [2*IdxW-1:0]          raddr_a, raddr_b, waddr;
  logic                       we;
  logic [trm_pkg::REL_W-1:0]  wdata, rdata_a, rdata_b;
  logic [trm_pkg::REL_W-1:0]  col_value, diag_value;
  logic                       diag_ready;
  trm_pkg::trm_arith_ctl_t    arith_ctl;
  logic [IdxW-1:0]            res_col;
  logic [trm_pkg::REL_W-1:0]  res_value;

  // The rate register takes a write on any cycle; the user keeps writes to idle time.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rate_q <= cfg_data_i;
    end
  end

  trm_ctrl #(
    .MAX_INDIVIDUALS (MAX_INDIVIDUALS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .sire_i       (sire_index_i),
    .dam_i        (dam_index_i),
    .new_ped_i    (new_pedigree_i),
    .busy_o       (busy),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .col_value_i  (col_value),
    .diag_value_i (diag_value),
    .diag_ready_i (diag_ready),
    .arith_ctl_o  (arith_ctl),
    .res_valid_o  (result_strobe_o),
    .res_col_o    (res_col),
    .res_value_o  (res_value),
    .res_flag_o   (parent_flagged_o),
    .res_full_o   (capacity_full_o),
    .res_last_o   (last_of_row_o)
  );

  trm_arith u_arith (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (arith_ctl),
    .rate_i       (rate_q),
    .rdata_a_i    (rdata_a),
    .rdata_b_i    (rdata_b),
    .col_value_o  (col_value),
    .diag_value_o (diag_value),
    .diag_ready_o (diag_ready)
  );

  trm_store #(
    .IDX_W (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign column_index_o       = trm_pkg::COL_W'(res_col);
  assign relationship_value_o = trm_pkg::VAL_W'(res_value);

endmodule

`default_nettype wire

// ----- src/trm_checker.sv -----
// Port-level checks for the tetraploid relationship matrix core, bound to the top level.
// Depends on trm_pkg and tetraploid_relationship_matrix_core.

`default_nettype none

module trm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          result_strobe_o,
  input wire logic [trm_pkg::COL_W-1:0]     column_index_o,
  input wire logic [trm_pkg::VAL_W-1:0]     relationship_value_o,
  input wire logic                          parent_flagged_o,
  input wire logic                          capacity_full_o,
  input wire logic                          last_of_row_o
);

  // A taken entry either starts a row or is refused on the very next beat.
  a_accept_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || (result_strobe_o && capacity_full_o)))
    else $error("accepted entry neither started nor refused");

  // A refusal is a single empty beat.
  a_refusal_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && capacity_full_o) |->
      (last_of_row_o && !parent_flagged_o && relationship_value_o == '0 &&
       column_index_o == '0))
    else $error("refusal beat carries data");

  // The end of a row frees the block on the same cycle as the diagonal beat.
  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_strobe_o && last_of_row_o && !capacity_full_o))
    else $error("busy dropped without a final beat");

  // Off-diagonal beats only appear while a row is in progress.
  a_mid_row_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_of_row_o) |-> busy)
    else $error("mid-row beat outside a row");

  // Values saturate below 2^20.
  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (relationship_value_o[trm_pkg::VAL_W-1] == 1'b0))
    else $error("relationship value above saturation limit");

endmodule

bind tetraploid_relationship_matrix_core trm_checker u_trm_checker (.*);

`default_nettype wire
